// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the poller RTL.
// Needs i_clk and i_rst_n in the scope of every module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define MBP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define MBP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/core/mbp_pkg.sv =====
// Types, codes and constants of the two-station Modbus poller.
// No dependencies; used by every file of the block but assert_macros.svh.
package mbp_pkg;

    // Input command codes
    typedef enum logic [1:0] {
        CMD_POLL    = 2'd0,
        CMD_RX      = 2'd1,
        CMD_TIMEOUT = 2'd2
    } t_cmd;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_TX       = 2'd0,
        KIND_DIST     = 2'd1,
        KIND_MISMATCH = 2'd2,
        KIND_TIMEOUT  = 2'd3
    } t_kind;

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_ENABLED   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_REGISTER = 8'd1;
    localparam logic [15:0] START_REG_RESET = 16'd59;

    // Request frame contents
    localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
    localparam logic [7:0]  REG_COUNT_HI      = 8'h00;
    localparam logic [7:0]  REG_COUNT_LO      = 8'h02;
    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'hA001;

    // Position of a word within the request frame
    localparam logic [2:0] BEAT_STATION = 3'd0;
    localparam logic [2:0] BEAT_FUNC    = 3'd1;
    localparam logic [2:0] BEAT_REG_HI  = 3'd2;
    localparam logic [2:0] BEAT_REG_LO  = 3'd3;
    localparam logic [2:0] BEAT_CNT_HI  = 3'd4;
    localparam logic [2:0] BEAT_CNT_LO  = 3'd5;
    localparam logic [2:0] BEAT_CRC_LO  = 3'd6;
    localparam logic [2:0] BEAT_CRC_HI  = 3'd7;

    // Work handed from the front to the back
    typedef struct packed {
        t_kind       kind;
        logic [1:0]  station;
        logic [31:0] distance;
        logic [15:0] start_reg;
    } t_job;

    // Fold one byte into the Modbus CRC-16, LSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int j = 0; j < 8; j++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/mbp_if.sv =====
// Channel interfaces of the poller: command input, result output, register writes.
// Depends on mbp_pkg for the configuration widths.
interface mbp_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] rx_byte;

    modport source (output valid, command, rx_byte, input ready);
    modport sink   (input valid, command, rx_byte, output ready);
endinterface

interface mbp_res_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [7:0]         tx_byte;
    logic               frame_last;
    logic [1:0]         station;
    logic signed [31:0] distance;

    modport source (output valid, kind, tx_byte, frame_last, station, distance, input ready);
    modport sink   (input valid, kind, tx_byte, frame_last, station, distance, output ready);
endinterface

interface mbp_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mbp_pkg::CFG_IDX_W-1:0]  index;
    logic [mbp_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/mbp_front.sv =====
// Front of the poller: accepts command words, keeps the poll state and
// classifies each word into at most one job. Depends on mbp_pkg and mbp_if.
`include "assert_macros.svh"

module mbp_front #(
    parameter int RESPONSE_BYTES = 9
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mbp_cmd_if.sink       i_cmd,
    input  logic          i_port_enabled,
    input  logic [15:0]   i_start_reg,
    input  logic          i_job_ready,
    output logic          o_job_valid,
    output mbp_pkg::t_job o_job
);

    localparam int LAST = RESPONSE_BYTES - 1;
    localparam int CNTW = $clog2(RESPONSE_BYTES);
    localparam int IDXW = $clog2(RESPONSE_BYTES - 1);

    logic            r_busy, n_busy;
    logic [1:0]      r_station, n_station;
    logic [CNTW-1:0] r_rx_count, n_rx_count;
    logic [7:0]      r_resp [LAST];
    logic [7:0]      w_byte [RESPONSE_BYTES];
    logic            w_acc;
    logic            w_wr;
    mbp_pkg::t_cmd   w_cmd;

    // Accept whenever the queue has room for a job
    assign i_cmd.ready = i_job_ready;
    assign w_acc       = i_cmd.valid & i_cmd.ready;
    assign w_cmd       = mbp_pkg::t_cmd'(i_cmd.command);

    // Response view: stored bytes, with the incoming word as the final byte
    for (genvar g = 0; g < LAST; g++) begin : g_view
        assign w_byte[g] = r_resp[g];
    end
    assign w_byte[LAST] = i_cmd.rx_byte;

    // Classify the accepted word and work out the next state
    always_comb begin
        n_busy      = r_busy;
        n_station   = r_station;
        n_rx_count  = r_rx_count;
        w_wr        = 1'b0;
        o_job_valid = 1'b0;
        o_job       = '{kind: mbp_pkg::KIND_TX, station: r_station,
                        distance: 32'd0, start_reg: i_start_reg};
        if (w_acc) begin
            unique case (w_cmd)
                mbp_pkg::CMD_POLL: begin
                    if (i_port_enabled && !r_busy) begin
                        n_station     = (r_station == 2'd1) ? 2'd2 : 2'd1;
                        n_busy        = 1'b1;
                        n_rx_count    = '0;
                        o_job_valid   = 1'b1;
                        o_job.station = n_station;
                    end
                end
                mbp_pkg::CMD_RX: begin
                    if (r_busy && r_station != 2'd0) begin
                        if (r_rx_count == CNTW'(LAST)) begin
                            n_busy      = 1'b0;
                            n_rx_count  = '0;
                            o_job_valid = 1'b1;
                            if (w_byte[0] != {6'd0, r_station}) begin
                                o_job.kind = mbp_pkg::KIND_MISMATCH;
                            end else begin
                                o_job.kind     = mbp_pkg::KIND_DIST;
                                o_job.distance = {w_byte[5], w_byte[6], w_byte[3], w_byte[4]};
                            end
                        end else begin
                            n_rx_count = r_rx_count + 1'b1;
                            w_wr       = 1'b1;
                        end
                    end
                end
                mbp_pkg::CMD_TIMEOUT: begin
                    if (r_busy) begin
                        n_busy      = 1'b0;
                        n_station   = 2'd0;
                        n_rx_count  = '0;
                        o_job_valid = 1'b1;
                        o_job.kind  = mbp_pkg::KIND_TIMEOUT;
                    end
                end
                default: begin
                    // unused command code: drop
                end
            endcase
        end
    end

    // Hold poll state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_station  <= 2'd0;
            r_rx_count <= '0;
        end else begin
            r_busy     <= n_busy;
            r_station  <= n_station;
            r_rx_count <= n_rx_count;
        end
    end

    // Store response bytes ahead of the final one
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_resp[r_rx_count[IDXW-1:0]] <= i_cmd.rx_byte;
        end
    end

    `MBP_ASSERT(a_busy_has_station, r_busy |-> r_station != 2'd0, "busy with no station")
    `MBP_ASSERT(a_poll_busy_keeps, (w_acc && w_cmd == mbp_pkg::CMD_POLL && r_busy) |=> $stable(r_station), "poll while busy moved station")

endmodule

// ===== rtl/core/mbp_queue.sv =====
// Short job queue between the front and the back of the poller.
// Depends on mbp_pkg for the job type.
`include "assert_macros.svh"

module mbp_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    input  mbp_pkg::t_job i_push_job,
    output logic          o_push_ready,
    output logic          o_pop_valid,
    output mbp_pkg::t_job o_pop_job,
    input  logic          i_pop_ready
);

    localparam int PTRW = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);

    mbp_pkg::t_job   r_mem [DEPTH];
    logic [PTRW-1:0] r_wr, r_rd;
    logic [CNTW-1:0] r_count;
    logic            w_push, w_pop;

    assign o_push_ready = (r_count != CNTW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_job    = r_mem[r_rd];
    assign w_push       = i_push_valid & o_push_ready;
    assign w_pop        = o_pop_valid & i_pop_ready;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTRW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTRW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Write job storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_job;
        end
    end

    `MBP_ASSERT(a_count_bound, r_count <= CNTW'(DEPTH), "queue count beyond depth")

endmodule

// ===== rtl/core/mbp_back.sv =====
// Back of the poller: turns jobs into result words, serialising request
// frames with a running CRC. Depends on mbp_pkg and mbp_if.
`include "assert_macros.svh"

module mbp_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  mbp_pkg::t_job i_job,
    output logic          o_job_ready,
    mbp_res_if.source     o_res
);

    logic               r_active;
    mbp_pkg::t_job      r_job;
    logic [2:0]         r_beat;
    logic [15:0]        r_crc;
    logic               r_valid;
    mbp_pkg::t_kind     r_kind;
    logic [7:0]         r_tx;
    logic               r_last;
    logic [1:0]         r_station;
    logic signed [31:0] r_dist;
    logic               w_out_free, w_emit, w_done, w_take, w_is_tx;
    logic [7:0]         w_byte;

    assign w_out_free  = !r_valid || o_res.ready;
    assign w_emit      = r_active && w_out_free;
    assign w_is_tx     = (r_job.kind == mbp_pkg::KIND_TX);
    assign w_done      = w_emit && (!w_is_tx || r_beat == mbp_pkg::BEAT_CRC_HI);
    assign o_job_ready = !r_active || w_done;
    assign w_take      = i_job_valid && o_job_ready;

    // Select the frame byte for the current beat
    always_comb begin
        unique case (r_beat)
            mbp_pkg::BEAT_STATION: w_byte = {6'd0, r_job.station};
            mbp_pkg::BEAT_FUNC:    w_byte = mbp_pkg::FUNC_READ_HOLDING;
            mbp_pkg::BEAT_REG_HI:  w_byte = r_job.start_reg[15:8];
            mbp_pkg::BEAT_REG_LO:  w_byte = r_job.start_reg[7:0];
            mbp_pkg::BEAT_CNT_HI:  w_byte = mbp_pkg::REG_COUNT_HI;
            mbp_pkg::BEAT_CNT_LO:  w_byte = mbp_pkg::REG_COUNT_LO;
            mbp_pkg::BEAT_CRC_LO:  w_byte = r_crc[7:0];
            mbp_pkg::BEAT_CRC_HI:  w_byte = r_crc[15:8];
        endcase
    end

    // Hold job and output valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            if (w_take) begin
                r_active <= 1'b1;
            end else if (w_done) begin
                r_active <= 1'b0;
            end
            if (w_emit) begin
                r_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Load a job, then step through its beats and fold header bytes into the CRC
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_job  <= i_job;
            r_beat <= mbp_pkg::BEAT_STATION;
            r_crc  <= mbp_pkg::CRC_INIT;
        end else if (w_emit) begin
            r_beat <= r_beat + 1'b1;
            if (r_beat < mbp_pkg::BEAT_CRC_LO) begin
                r_crc <= mbp_pkg::crc_byte(r_crc, w_byte);
            end
        end
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_kind    <= r_job.kind;
            r_tx      <= w_is_tx ? w_byte : 8'd0;
            r_last    <= !w_is_tx || (r_beat == mbp_pkg::BEAT_CRC_HI);
            r_station <= r_job.station;
            r_dist    <= w_is_tx ? 32'sd0 : $signed(r_job.distance);
        end
    end

    assign o_res.valid      = r_valid;
    assign o_res.kind       = r_kind;
    assign o_res.tx_byte    = r_tx;
    assign o_res.frame_last = r_last;
    assign o_res.station    = r_station;
    assign o_res.distance   = r_dist;

    `MBP_ASSERT(a_beats_only_tx, (r_active && r_beat != mbp_pkg::BEAT_STATION) |-> w_is_tx, "non-frame job past first beat")
    `MBP_ASSERT(a_frame_end_marked, (w_emit && w_is_tx && r_beat == mbp_pkg::BEAT_CRC_HI) |=> (r_valid && r_last), "frame end not marked")

endmodule

// ===== rtl/core/modbus_two_station_distance_poller_core.sv =====
// Top level of the two-station Modbus RTU distance poller.
// Depends on mbp_pkg, mbp_if, mbp_front, mbp_queue and mbp_back.
//
// Channels: i_cmd takes command words (poll tick, received byte, timeout),
// o_res gives result words, i_cfg writes the two registers (index 0 port
// enable, index 1 start register) and is always ready.
// A poll tick accepted while the port is enabled and idle yields eight
// transmit words, one per cycle while o_res is ready, via the queue and
// the back's output register. The final response byte (distance or mismatch)
// or a timeout yields one word the same way. Other commands yield nothing.
// Throughput: a command word is taken every cycle while the job queue has
// room; the result side emits one word per cycle while o_res is ready, so
// a poll occupies the output for eight words and a single result for one.
// The request CRC is built one byte per cycle as unstalled frame words leave.
// Reset clears the poll state, the queue and the output valid flag, and sets
// the registers to port disabled and start register 59.
// When o_res stalls, the output word holds, the back stops, the queue fills
// and then i_cmd.ready drops; nothing is lost.
module modbus_two_station_distance_poller_core #(
    parameter int RESPONSE_BYTES = 9,
    parameter int QUEUE_DEPTH    = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mbp_cmd_if.sink   i_cmd,
    mbp_cfg_if.sink   i_cfg,
    mbp_res_if.source o_res
);

    logic          r_port_enabled;
    logic [15:0]   r_start_reg;
    logic          w_push_valid, w_push_ready;
    logic          w_pop_valid, w_pop_ready;
    mbp_pkg::t_job w_push_job, w_pop_job;

    // Register writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_enabled <= 1'b0;
            r_start_reg    <= mbp_pkg::START_REG_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                mbp_pkg::CFG_PORT_ENABLED:   r_port_enabled <= i_cfg.data[0];
                mbp_pkg::CFG_START_REGISTER: r_start_reg    <= i_cfg.data[15:0];
                default: begin
                    // no register here: drop
                end
            endcase
        end
    end

    mbp_front #(
        .RESPONSE_BYTES (RESPONSE_BYTES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (i_cmd),
        .i_port_enabled (r_port_enabled),
        .i_start_reg    (r_start_reg),
        .i_job_ready    (w_push_ready),
        .o_job_valid    (w_push_valid),
        .o_job          (w_push_job)
    );

    mbp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .i_push_job   (w_push_job),
        .o_push_ready (w_push_ready),
        .o_pop_valid  (w_pop_valid),
        .o_pop_job    (w_pop_job),
        .i_pop_ready  (w_pop_ready)
    );

    mbp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_pop_valid),
        .i_job       (w_pop_job),
        .o_job_ready (w_pop_ready),
        .o_res       (o_res)
    );

endmodule

// ===== sim/tb_modbus_two_station_distance_poller_core.sv =====
// Self-checking testbench for the two-station Modbus distance poller core.
// Depends on mbp_pkg, the mbp_if channel interfaces and the core RTL; an in-bench
// predictor works out every result word and a checker compares each one as it leaves.
module tb_modbus_two_station_distance_poller_core;

    localparam int          CLK_PERIOD    = 12;
    localparam int          RESP_LEN      = 9;
    localparam int          SETTLE_CYCLES = 24;
    localparam int          LIMIT_CYCLES  = 1000000;
    localparam int          MAX_REPORTS   = 10;
    localparam int          PHASE_ITEMS   = 36;
    localparam logic [1:0]  CMD_UNUSED    = 2'd3;
    localparam logic [7:0]  CFG_NO_SUCH   = 8'd2;

    // One expected result word
    typedef struct packed {
        mbp_pkg::t_kind     kind;
        logic [7:0]         tx_byte;
        logic               frame_last;
        logic [1:0]         station;
        logic signed [31:0] distance;
    } t_res_word;

    logic i_clk;
    logic i_rst_n;

    mbp_cmd_if cmd_ch ();
    mbp_cfg_if cfg_ch ();
    mbp_res_if res_ch ();

    modbus_two_station_distance_poller_core #(
        .RESPONSE_BYTES(RESP_LEN)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_ch),
        .i_cfg  (cfg_ch),
        .o_res  (res_ch)
    );

    // Poller state as the predictor sees it
    logic        port_on;
    logic [15:0] start_addr;
    logic        link_busy;
    logic [1:0]  cur_station;
    int unsigned bytes_seen;
    logic [7:0]  reply_buf [RESP_LEN];
    logic [31:0] dist_one;
    logic [31:0] dist_two;

    t_res_word   expected_words [$];
    int unsigned fault_count;
    int unsigned taken_items;
    bit          gaps_on;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("FAILURE");
        $finish;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Byte with a bias towards the sign and range edges
    function automatic logic [7:0] pick_byte();
        logic [7:0] edges [4];
        edges = '{8'h00, 8'hFF, 8'h80, 8'h7F};
        if ($urandom_range(0, 7) == 0) return edges[$urandom_range(0, 3)];
        return 8'($urandom());
    endfunction

    // Modbus CRC-16 of the six request bytes
    function automatic logic [15:0] request_crc(logic [7:0] frame [8]);
        logic [15:0] acc;
        acc = 16'hFFFF;
        for (int i = 0; i < 6; i++) begin
            acc = acc ^ {8'h00, frame[i]};
            for (int b = 0; b < 8; b++) begin
                if (acc[0]) acc = (acc >> 1) ^ 16'hA001;
                else        acc = acc >> 1;
            end
        end
        return acc;
    endfunction

    function automatic void push_word(mbp_pkg::t_kind kind, logic [7:0] tx, logic last,
                                      logic [1:0] st, logic [31:0] dist_val);
        t_res_word w;
        w.kind       = kind;
        w.tx_byte    = tx;
        w.frame_last = last;
        w.station    = st;
        w.distance   = dist_val;
        expected_words.push_back(w);
    endfunction

    // Advance the poller state by one command; return 1 if the block acts on it
    function automatic bit poller_advance(logic [1:0] cmd, logic [7:0] rx);
        logic [7:0]  frame [8];
        logic [15:0] crc;
        logic [31:0] dist_val;
        logic [1:0]  old_station;
        case (cmd)
            mbp_pkg::CMD_POLL: begin
                if (!port_on || link_busy) return 1'b0;
                cur_station = (cur_station == 2'd1) ? 2'd2 : 2'd1;
                frame[0] = {6'd0, cur_station};
                frame[1] = mbp_pkg::FUNC_READ_HOLDING;
                frame[2] = start_addr[15:8];
                frame[3] = start_addr[7:0];
                frame[4] = mbp_pkg::REG_COUNT_HI;
                frame[5] = mbp_pkg::REG_COUNT_LO;
                crc      = request_crc(frame);
                frame[6] = crc[7:0];
                frame[7] = crc[15:8];
                link_busy  = 1'b1;
                bytes_seen = 0;
                for (int i = 0; i < 8; i++)
                    push_word(mbp_pkg::KIND_TX, frame[i], i == 7, cur_station, 32'd0);
                return 1'b1;
            end
            mbp_pkg::CMD_RX: begin
                if (!link_busy || cur_station == 2'd0) return 1'b0;
                if (bytes_seen < RESP_LEN) reply_buf[bytes_seen] = rx;
                bytes_seen++;
                if (bytes_seen < RESP_LEN) return 1'b1;
                link_busy  = 1'b0;
                bytes_seen = 0;
                if (reply_buf[0] != {6'd0, cur_station}) begin
                    push_word(mbp_pkg::KIND_MISMATCH, 8'd0, 1'b1, cur_station, 32'd0);
                end else begin
                    dist_val = {reply_buf[5], reply_buf[6], reply_buf[3], reply_buf[4]};
                    if (cur_station == 2'd1) dist_one = dist_val;
                    else                     dist_two = dist_val;
                    push_word(mbp_pkg::KIND_DIST, 8'd0, 1'b1, cur_station, dist_val);
                end
                return 1'b1;
            end
            mbp_pkg::CMD_TIMEOUT: begin
                if (!link_busy) return 1'b0;
                old_station = cur_station;
                link_busy   = 1'b0;
                cur_station = 2'd0;
                bytes_seen  = 0;
                push_word(mbp_pkg::KIND_TIMEOUT, 8'd0, 1'b1, old_station, 32'd0);
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Send one command word, then predict what it causes
    task automatic send_word(logic [1:0] cmd, logic [7:0] rx);
        int unsigned gap;
        gap = gap_len();
        if (gap != 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.command <= cmd;
        cmd_ch.rx_byte <= rx;
        do @(posedge i_clk); while (!cmd_ch.ready);
        if (poller_advance(cmd, rx)) taken_items++;
    endtask

    // Drop valid and hold the sender until every expected word has left
    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
    endtask

    // Drain, let the queue settle, then write one register
    task automatic write_register(logic [7:0] idx, logic [15:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == mbp_pkg::CFG_PORT_ENABLED)        port_on    = value[0];
        else if (idx == mbp_pkg::CFG_START_REGISTER) start_addr = value;
    endtask

    task automatic send_reply(logic [7:0] bytes [RESP_LEN]);
        for (int i = 0; i < RESP_LEN; i++) send_word(mbp_pkg::CMD_RX, bytes[i]);
    endtask

    // Record a fault; report only the first few
    function automatic void note_fault(string msg);
        fault_count++;
        if (fault_count <= MAX_REPORTS) $display("%t: %s", $realtime, msg);
    endfunction

    // Result checker
    always @(posedge i_clk) begin : check_words
        t_res_word want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_words.size() == 0) begin
                note_fault($sformatf("unexpected word kind=%0d tx=%02h last=%0b st=%0d dist=%0d",
                           res_ch.kind, res_ch.tx_byte, res_ch.frame_last, res_ch.station,
                           res_ch.distance));
            end else begin
                want = expected_words.pop_front();
                if (res_ch.kind !== want.kind || res_ch.tx_byte !== want.tx_byte ||
                    res_ch.frame_last !== want.frame_last ||
                    res_ch.station !== want.station || res_ch.distance !== want.distance) begin
                    note_fault($sformatf({"mismatch exp kind=%0d tx=%02h last=%0b st=%0d ",
                               "dist=%0d got kind=%0d tx=%02h last=%0b st=%0d dist=%0d"},
                               want.kind, want.tx_byte, want.frame_last, want.station,
                               want.distance, res_ch.kind, res_ch.tx_byte,
                               res_ch.frame_last, res_ch.station, res_ch.distance));
                end
            end
        end
    end

    // Result side back-pressure
    initial begin : stall_results
        int unsigned hold;
        logic        level;
        res_ch.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (gaps_on && $urandom_range(0, 3) == 0) begin
                level = 1'b0;
                hold  = gap_len() + 1;
            end else begin
                level = 1'b1;
                hold  = $urandom_range(1, 6);
            end
            res_ch.ready <= level;
            repeat (hold) @(posedge i_clk);
        end
    end

    // Port closed: every command must be ignored
    task automatic test_port_disabled();
        send_word(mbp_pkg::CMD_POLL, 8'h00);
        send_word(mbp_pkg::CMD_RX, 8'hFF);
        send_word(mbp_pkg::CMD_TIMEOUT, 8'h00);
        send_word(CMD_UNUSED, 8'hA5);
    endtask

    // Directed frames: distance at the negative limit, busy poll, timeout, mismatch
    task automatic test_directed_frames();
        write_register(mbp_pkg::CFG_PORT_ENABLED, 16'd1);
        send_word(mbp_pkg::CMD_POLL, 8'h00);
        send_reply('{8'h01, 8'h03, 8'h04, 8'h00, 8'h00, 8'h80, 8'h00, 8'hAA, 8'h55});
        // station 2: ignored poll and unused code while busy, then timeout
        send_word(mbp_pkg::CMD_POLL, 8'hFF);
        send_word(mbp_pkg::CMD_POLL, 8'h00);
        send_word(CMD_UNUSED, 8'h00);
        send_word(mbp_pkg::CMD_RX, 8'h02);
        send_word(mbp_pkg::CMD_TIMEOUT, 8'h00);
        // station back to 1; reply names station 2
        send_word(mbp_pkg::CMD_POLL, 8'h00);
        send_reply('{8'h02, 8'h03, 8'h04, 8'hFF, 8'hFF, 8'h7F, 8'hFF, 8'h00, 8'hFF});
    endtask

    // Register edges: unknown index, start register at both limits
    task automatic test_register_writes();
        write_register(CFG_NO_SUCH, 16'hFFFF);
        send_word(mbp_pkg::CMD_POLL, 8'h00);
        send_word(mbp_pkg::CMD_TIMEOUT, 8'h00);
        write_register(mbp_pkg::CFG_START_REGISTER, 16'hFFFF);
        send_word(mbp_pkg::CMD_POLL, 8'h00);
        send_reply('{8'h02, 8'h03, 8'h04, 8'hFF, 8'hFF, 8'h7F, 8'hFF, 8'h00, 8'h00});
        write_register(mbp_pkg::CFG_START_REGISTER, 16'h0000);
        send_word(mbp_pkg::CMD_POLL, 8'h00);
        send_word(mbp_pkg::CMD_TIMEOUT, 8'h00);
    endtask

    // One poll followed by a reply of random shape
    task automatic run_exchange();
        int unsigned shape;
        int unsigned cut;
        logic [7:0]  b;
        if ($urandom_range(0, 99) < 5) wait_drained();
        send_word(mbp_pkg::CMD_POLL, pick_byte());
        if (!link_busy) return;
        shape = $urandom_range(0, 99);
        if (shape < 65) begin
            // mostly well-formed reply, odd stray word in between
            for (int i = 0; i < RESP_LEN; i++) begin
                if ($urandom_range(0, 19) == 0)
                    send_word($urandom_range(0, 1) ? mbp_pkg::CMD_POLL : CMD_UNUSED,
                              pick_byte());
                b = pick_byte();
                if (i == 0 && $urandom_range(0, 99) < 85) b = {6'd0, cur_station};
                send_word(mbp_pkg::CMD_RX, b);
            end
        end else if (shape < 80) begin
            // reply cut short by a timeout
            cut = $urandom_range(0, RESP_LEN - 1);
            for (int i = 0; i < cut; i++) send_word(mbp_pkg::CMD_RX, pick_byte());
            send_word(mbp_pkg::CMD_TIMEOUT, pick_byte());
        end else if (shape < 90) begin
            // full reply, then bytes and a timeout while idle
            for (int i = 0; i < RESP_LEN; i++)
                send_word(mbp_pkg::CMD_RX, (i == 0) ? {6'd0, cur_station} : pick_byte());
            cut = $urandom_range(1, 3);
            for (int i = 0; i < cut; i++) send_word(mbp_pkg::CMD_RX, pick_byte());
            send_word(mbp_pkg::CMD_TIMEOUT, 8'h00);
        end else begin
            // wrong station in the reply
            send_word(mbp_pkg::CMD_RX, {6'd0, cur_station} ^ 8'h03);
            for (int i = 1; i < RESP_LEN; i++) send_word(mbp_pkg::CMD_RX, pick_byte());
        end
    endtask

    task automatic run_phase(int unsigned target, bit with_gaps);
        int unsigned base;
        gaps_on = with_gaps;
        base    = taken_items;
        while (taken_items - base < target) run_exchange();
    endtask

    // Random traffic over several register settings
    task automatic test_random_traffic();
        write_register(mbp_pkg::CFG_START_REGISTER, 16'($urandom()));
        run_phase(PHASE_ITEMS, 1'b1);
        write_register(mbp_pkg::CFG_START_REGISTER, 16'h0000);
        run_phase(PHASE_ITEMS, 1'b0);
        write_register(mbp_pkg::CFG_START_REGISTER, 16'hFFFF);
        run_phase(PHASE_ITEMS, 1'b1);
        // port closed: random noise, nothing expected
        write_register(mbp_pkg::CFG_PORT_ENABLED, 16'd0);
        for (int i = 0; i < 12; i++) send_word(2'($urandom()), pick_byte());
        write_register(mbp_pkg::CFG_PORT_ENABLED, 16'd1);
        write_register(mbp_pkg::CFG_START_REGISTER, mbp_pkg::START_REG_RESET);
        run_phase(PHASE_ITEMS, 1'b1);
        write_register(mbp_pkg::CFG_START_REGISTER, 16'($urandom()));
        run_phase(PHASE_ITEMS, 1'b1);
    endtask

    // Main sequence
    initial begin
        cmd_ch.valid   <= 1'b0;
        cmd_ch.command <= mbp_pkg::CMD_POLL;
        cmd_ch.rx_byte <= 8'h00;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.index   <= mbp_pkg::CFG_PORT_ENABLED;
        cfg_ch.data    <= 16'h0000;
        i_rst_n        <= 1'b0;
        port_on     = 1'b0;
        start_addr  = mbp_pkg::START_REG_RESET;
        link_busy   = 1'b0;
        cur_station = 2'd0;
        bytes_seen  = 0;
        dist_one    = 32'd0;
        dist_two    = 32'd0;
        fault_count = 0;
        taken_items = 0;
        gaps_on     = 1'b1;
        for (int i = 0; i < RESP_LEN; i++) reply_buf[i] = 8'h00;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_port_disabled();
        test_directed_frames();
        test_register_writes();
        test_random_traffic();

        // Drain and let the pipeline settle before the verdict
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fault_count == 0 && expected_words.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== modbus_two_station_distance_poller_core.f =====
+incdir+rtl/core
rtl/core/mbp_pkg.sv
rtl/core/mbp_if.sv
rtl/core/mbp_front.sv
rtl/core/mbp_queue.sv
rtl/core/mbp_back.sv
rtl/core/modbus_two_station_distance_poller_core.sv
sim/tb_modbus_two_station_distance_poller_core.sv
